>>> src/afs_pkg.sv
// Package for the identifier allocator with a free stack.
// Holds the request kinds, status codes and controller state type.
// Depends on nothing.
`default_nettype none

package afs_pkg;

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

`default_nettype wire

>>> src/afs_ram.sv
// Simple dual-port synchronous memory: one write port, one read port.
// Read data is registered and holds while no read is issued.
// Depends on nothing.
`default_nettype none

module afs_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/id_allocator_free_stack_core.sv
// Top level of the identifier allocator: controller, alive map and free stack.
// Uses afs_pkg and two instances of afs_ram.
//
//   channel | direction | tdata (low bit up)                   | tuser
//   req     | in        | entity_id                            | req_type
//   rsp     | out       | result_id, is_alive, live_count      | status
//
// The memories are read in the cycle a word is accepted and written back in ST_EXEC,
// in the cycle the result is registered.
// A new request word is accepted while the previous result waits on rsp; its
// ST_EXEC step stalls until the output register is free.
// Reset and clear all take effect at once: alive bits at or above the fresh
// counter are treated as zero, so no clearing pass over the map is needed.
`default_nettype none

module id_allocator_free_stack_core #(
   parameter int  ID_COUNT = 1024,
   localparam int ID_W     = $clog2(ID_COUNT),
   localparam int REQ_W    = ((ID_W + 7) / 8) * 8,
   localparam int RSP_W    = ((2 * ID_W + 1 + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // entity_id
   input  wire logic [1:0]       req_tuser,  // req_type
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [RSP_W-1:0] rsp_tdata,  // result_id, is_alive, live_count
   output logic      [1:0]       rsp_tuser   // status
);

   localparam int CNT_W = ID_W + 1;
   localparam int RSP_FIELD_W = 2 * ID_W + 1;
   localparam logic [CNT_W-1:0] ID_LIMIT = CNT_W'(ID_COUNT);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   afs_pkg::state_type state_ff, state_in;
   logic [1:0]       kind_ff, kind_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic             in_range_ff, in_range_in;
   logic [CNT_W-1:0] free_top_ff, free_top_in;
   logic [CNT_W-1:0] fresh_next_ff, fresh_next_in;
   logic [ID_W-1:0]  count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_alive_ff, rsp_alive_in;
   logic [ID_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [ID_W-1:0]  req_id;
   logic             req_in_range;
   logic             accept;
   logic             exec_go;
   logic             alive_rd_en;
   logic [0:0]       alive_rd_data;
   logic             alive_wr_en;
   logic [0:0]       alive_wr_data;
   logic [ID_W-1:0]  alive_wr_addr;
   logic             stack_rd_en;
   logic [ID_W-1:0]  stack_rd_addr;
   logic [ID_W-1:0]  stack_rd_data;
   logic             stack_wr_en;
   logic             alive_now;
   logic [RSP_FIELD_W-1:0] rsp_bits;

   assign req_id       = req_tdata[ID_W-1:0];
   assign req_in_range = {1'b0, req_id} < ID_LIMIT;
   assign req_tready   = (state_ff == afs_pkg::ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign exec_go      = (state_ff == afs_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign alive_rd_en   = accept && req_in_range;
   assign stack_rd_en   = accept && (req_tuser == afs_pkg::REQ_ALLOC) && (free_top_ff != '0);
   assign stack_rd_addr = ID_W'(free_top_ff - CNT_ONE);

   assign alive_now = alive_rd_data[0] && in_range_ff && (id_ff != '0)
                      && ({1'b0, id_ff} < fresh_next_ff);

   afs_ram #(
      .WIDTH (1),
      .DEPTH (ID_COUNT)
   ) u_alive_map (
      .clock   (clock),
      .wr_en   (alive_wr_en),
      .wr_addr (alive_wr_addr),
      .wr_data (alive_wr_data),
      .rd_en   (alive_rd_en),
      .rd_addr (req_id),
      .rd_data (alive_rd_data)
   );

   afs_ram #(
      .WIDTH (ID_W),
      .DEPTH (ID_COUNT)
   ) u_free_stack (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (ID_W'(free_top_ff)),
      .wr_data (id_ff),
      .rd_en   (stack_rd_en),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      in_range_in   = in_range_ff;
      free_top_in   = free_top_ff;
      fresh_next_in = fresh_next_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_alive_in  = rsp_alive_ff;
      rsp_count_in  = rsp_count_ff;
      alive_wr_en   = 1'b0;
      alive_wr_addr = id_ff;
      alive_wr_data = 1'b0;
      stack_wr_en   = 1'b0;

      unique case (state_ff)
         afs_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in     = req_tuser;
               id_in       = req_id;
               in_range_in = req_in_range;
               state_in    = afs_pkg::ST_EXEC;
            end
         end
         afs_pkg::ST_EXEC: begin
            if (exec_go) begin
               rsp_id_in     = '0;
               rsp_status_in = afs_pkg::STATUS_DONE;
               rsp_alive_in  = 1'b0;
               unique case (kind_ff)
                  afs_pkg::REQ_ALLOC: begin
                     if (free_top_ff != '0) begin
                        free_top_in   = free_top_ff - CNT_ONE;
                        rsp_id_in     = stack_rd_data;
                        alive_wr_addr = stack_rd_data;
                        alive_wr_data = 1'b1;
                        alive_wr_en   = 1'b1;
                        count_in      = count_ff + ID_W'(1);
                     end else if (fresh_next_ff < ID_LIMIT) begin
                        fresh_next_in = fresh_next_ff + CNT_ONE;
                        rsp_id_in     = ID_W'(fresh_next_ff);
                        alive_wr_addr = ID_W'(fresh_next_ff);
                        alive_wr_data = 1'b1;
                        alive_wr_en   = 1'b1;
                        count_in      = count_ff + ID_W'(1);
                     end else begin
                        rsp_status_in = afs_pkg::STATUS_FULL;
                     end
                  end
                  afs_pkg::REQ_FREE: begin
                     if (!alive_now) begin
                        rsp_status_in = afs_pkg::STATUS_IGNORED;
                     end else begin
                        alive_wr_en = 1'b1;
                        if (count_ff != '0) begin
                           count_in = count_ff - ID_W'(1);
                        end
                        if (free_top_ff < ID_LIMIT) begin
                           stack_wr_en = 1'b1;
                           free_top_in = free_top_ff + CNT_ONE;
                        end
                     end
                  end
                  afs_pkg::REQ_QUERY: begin
                     rsp_alive_in = alive_now;
                  end
                  afs_pkg::REQ_CLEAR: begin
                     free_top_in   = '0;
                     fresh_next_in = CNT_ONE;
                     count_in      = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
               rsp_valid_in = 1'b1;
               state_in     = afs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = afs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= afs_pkg::ST_IDLE;
         free_top_ff   <= '0;
         fresh_next_ff <= CNT_ONE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_top_ff   <= free_top_in;
         fresh_next_ff <= fresh_next_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      in_range_ff   <= in_range_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_alive_ff  <= rsp_alive_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_bits   = {rsp_count_ff, rsp_alive_ff, rsp_id_ff};
   assign rsp_tdata  = RSP_W'(rsp_bits);
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire
